/* sv/lce_pkg.sv */
// ----------------------------------------------------------------------------
// lce_pkg
// Shared types and constants for the Lorentzian conductance evaluator.
// ----------------------------------------------------------------------------
package lce_pkg;

  localparam int unsigned ATAN_STAGES_DEF = 24;

  localparam int unsigned D_W   = 59;   // energy offsets, signed Q.48
  localparam int unsigned CW    = 64;   // CORDIC vector width
  localparam int unsigned ZW    = 32;   // angle width, Q2.30
  localparam int unsigned DIV_W = 120;  // divider remainder width
  localparam int unsigned QW    = 24;   // quotient bits

  localparam logic [24:0] ONE_Q24 = 25'h100_0000;

  // normalization: greedy doubling search, then one final doubling
  localparam int unsigned NORM_STAGES = 7;
  localparam int unsigned NORM_SHIFT [NORM_STAGES] = '{32, 16, 8, 4, 2, 1, 1};
  localparam int unsigned NORM_LIMIT [NORM_STAGES] = '{25, 41, 49, 53, 55, 56, 57};

  // round(atan(2^-i) * 2^30)
  localparam logic [ZW-1:0] ATAN_TABLE [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  localparam logic [1:0] OP_ZERO_BIAS = 2'd0;
  localparam logic [1:0] OP_STATIC    = 2'd1;
  localparam logic [1:0] OP_DIFF      = 2'd2;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_TRANS,
    MODE_STATIC,
    MODE_DIFF
  } mode_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] fermi_energy;
    logic [31:0] bias;
    logic [24:0] division;
    logic [31:0] level_energy;
    logic [30:0] coupling_left;
    logic [30:0] coupling_right;
  } lce_in_t;

  typedef struct packed {
    logic [24:0] conductance;
    logic        divide_error;
  } lce_out_t;

  typedef struct packed {
    logic          sat;
    logic [QW-1:0] q;
  } lce_quot_t;

  // travels beside the normalize/CORDIC chain
  typedef struct packed {
    mode_e          mode;
    logic           vpos;
    logic           vneg;
    logic [24:0]    eta;
    logic [D_W-1:0] da;
    logic [D_W-1:0] db;
    logic [31:0]    s;
    logic [31:0]    vmag;
    logic [61:0]    gg;
  } lce_side_t;

  // travels beside the divider chain
  typedef struct packed {
    mode_e       mode;
    logic        pos;
    logic        err;
    logic [24:0] eta;
  } lce_tail_t;

endpackage

/* sv/lce_norm_cell.sv */
// ----------------------------------------------------------------------------
// lce_norm_cell
// One step of the CORDIC input normalization: doubles the vector SHIFT
// times when both magnitudes stay below 2^LIMIT.
// ----------------------------------------------------------------------------
module lce_norm_cell
  import lce_pkg::*;
#(
  parameter int unsigned SHIFT = 1,
  parameter int unsigned LIMIT = 57
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o
);

  localparam logic signed [CW-1:0] LimPos = {{(CW-1){1'b0}}, 1'b1} << LIMIT;
  localparam logic signed [CW-1:0] LimNeg = -LimPos;

  logic                 fits;
  logic signed [CW-1:0] x_d, y_d, x_q, y_q;

  assign fits = (x_i < LimPos) && (x_i > LimNeg) && (y_i < LimPos) && (y_i > LimNeg);
  assign x_d  = fits ? (x_i <<< SHIFT) : x_i;
  assign y_d  = fits ? (y_i <<< SHIFT) : y_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

/* sv/lce_cordic_cell.sv */
// ----------------------------------------------------------------------------
// lce_cordic_cell
// One vectoring micro-rotation; drives y toward zero and accumulates angle.
// ----------------------------------------------------------------------------
module lce_cordic_cell
  import lce_pkg::*;
#(
  parameter int unsigned STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] Angle = ATAN_TABLE[STAGE];

  logic signed [CW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;

  assign xs = x_i >>> STAGE;
  assign ys = y_i >>> STAGE;

  always_comb begin
    if (!y_i[CW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + Angle;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - Angle;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

/* sv/lce_div_cell.sv */
// ----------------------------------------------------------------------------
// lce_div_cell
// One restoring-division step of the saturating fraction divider. The head
// cell only checks for a quotient of one or more.
// ----------------------------------------------------------------------------
module lce_div_cell
  import lce_pkg::*;
#(
  parameter bit INIT = 1'b0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DIV_W-1:0] rem_i,
  input  logic [DIV_W-1:0] den_i,
  input  lce_quot_t        quot_i,
  output logic [DIV_W-1:0] rem_o,
  output logic [DIV_W-1:0] den_o,
  output lce_quot_t        quot_o
);

  logic [DIV_W-1:0] rem2, rem_d, rem_q, den_q;
  logic             ge;
  lce_quot_t        quot_d, quot_q;

  // remainder stays below den < 2^(DIV_W-1), so the top bit is never lost
  assign rem2 = {rem_i[DIV_W-2:0], 1'b0};
  assign ge   = rem2 >= den_i;

  always_comb begin
    if (INIT) begin
      quot_d.sat = rem_i >= den_i;
      quot_d.q   = '0;
      rem_d      = rem_i;
    end else begin
      quot_d.sat = quot_i.sat;
      quot_d.q   = {quot_i.q[QW-2:0], ge};
      rem_d      = ge ? (rem2 - den_i) : rem2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      den_q  <= den_i;
      quot_q <= quot_d;
    end
  end

  assign rem_o  = rem_q;
  assign den_o  = den_q;
  assign quot_o = quot_q;

endmodule

/* sv/lorentzian_conductance_eval.sv */
// ----------------------------------------------------------------------------
// lorentzian_conductance_eval
// Single-level Breit-Wigner transmission: zero-bias, static and differential
// conductance, pipelined through normalize, CORDIC and divider cell chains.
//
//   Channel  Dir  Handshake                 Payload
//   in       in   in_valid_i / in_stall_o   lce_in_t
//   out      out  out_valid_o / out_stall_i lce_out_t
//
// One transaction per cycle sustained while the output is not stalled.
// The pipeline is made of the 7 normalize cells, the ATAN_STAGES CORDIC
// cells and the 25 divider cells, plus 8 arithmetic stages.
// Reset clears only the valid pipeline; no clearing pass.
// A stalled result in the output register freezes the whole pipeline and
// stalls the input.
// ----------------------------------------------------------------------------
module lorentzian_conductance_eval
  import lce_pkg::*;
#(
  parameter int unsigned ATAN_STAGES = ATAN_STAGES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lce_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lce_out_t out_data_o
);

  localparam int unsigned ChainLen = NORM_STAGES + ATAN_STAGES;
  localparam int unsigned DivLen   = QW + 1;
  localparam int unsigned Latency  = 2 + ChainLen + 4 + DivLen + 2;

  typedef struct packed {
    logic [1:0]  op;
    logic [32:0] dd;
    logic [57:0] ev;
    logic [31:0] v;
    logic [24:0] eta;
    logic [31:0] s;
    logic [61:0] gg;
    logic [31:0] vmag;
    logic        vpos;
    logic        vneg;
  } s1_t;

  typedef struct packed {
    mode_e       mode;
    logic        pos;
    logic        err;
    logic [24:0] eta;
    logic [31:0] thm;
    logic [63:0] vs;
    logic [57:0] ada;
    logic [57:0] adb;
    logic [31:0] s;
    logic [61:0] gg;
  } e1_t;

  typedef struct packed {
    lce_tail_t   tail;
    logic [62:0] ph;
    logic [63:0] pl;
    logic [63:0] vs;
    logic [57:0] ahh;
    logic [57:0] ahl;
    logic [57:0] all;
    logic [57:0] bhh;
    logic [57:0] bhl;
    logic [57:0] bll;
    logic [63:0] ss;
    logic [61:0] gg;
  } e2_t;

  typedef struct packed {
    lce_tail_t        tail;
    logic [DIV_W-1:0] snum;
    logic [63:0]      vs;
    logic [115:0]     sqa;
    logic [115:0]     sqb;
    logic [63:0]      ss;
    logic [61:0]      gg;
  } e3_t;

  typedef struct packed {
    mode_e       mode;
    logic        pos;
    logic        err;
    logic [24:0] qa;
    logic [49:0] pa;
    logic [49:0] pb;
  } f1_t;

  // ---------------------------------------------------------------- control
  logic               en;
  logic [Latency-1:0] vld_q;

  assign en         = !(vld_q[Latency-1] && out_stall_i);
  assign in_stall_o = !en;
  assign out_valid_o = vld_q[Latency-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Latency-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic [24:0] eta_c;
  s1_t         s1_d, s1_q;

  assign eta_c = (in_data_i.division > ONE_Q24) ? ONE_Q24 : in_data_i.division;

  always_comb begin
    s1_d.op   = in_data_i.operation;
    s1_d.dd   = {in_data_i.fermi_energy[31], in_data_i.fermi_energy}
              - {in_data_i.level_energy[31], in_data_i.level_energy};
    s1_d.ev   = $signed({1'b0, eta_c}) * $signed(in_data_i.bias);
    s1_d.v    = in_data_i.bias;
    s1_d.eta  = eta_c;
    s1_d.s    = {1'b0, in_data_i.coupling_left} + {1'b0, in_data_i.coupling_right};
    s1_d.gg   = in_data_i.coupling_left * in_data_i.coupling_right;
    s1_d.vmag = in_data_i.bias[31] ? (32'd0 - in_data_i.bias) : in_data_i.bias;
    s1_d.vpos = !in_data_i.bias[31] && (in_data_i.bias != 32'd0);
    s1_d.vneg = in_data_i.bias[31];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [D_W-1:0]       d0, d1, d2;
  mode_e                mode_d;
  lce_side_t            side2_d, side2_q;
  logic signed [CW-1:0] cx_q;
  logic signed [CW-1:0] cy_q [2];

  assign d0 = {{2{s1_q.dd[32]}}, s1_q.dd, 24'b0};
  assign d1 = d0 + {s1_q.ev[57], s1_q.ev};
  assign d2 = d0 + {s1_q.ev[57], s1_q.ev} - {{3{s1_q.v[31]}}, s1_q.v, 24'b0};

  always_comb begin
    unique case (s1_q.op)
      OP_ZERO_BIAS: mode_d = MODE_TRANS;
      OP_STATIC:    mode_d = (s1_q.vpos || s1_q.vneg) ? MODE_STATIC : MODE_TRANS;
      OP_DIFF:      mode_d = MODE_DIFF;
      default:      mode_d = MODE_NONE;
    endcase
  end

  always_comb begin
    side2_d.mode = mode_d;
    side2_d.vpos = s1_q.vpos;
    side2_d.vneg = s1_q.vneg;
    side2_d.eta  = s1_q.eta;
    side2_d.da   = (mode_d == MODE_DIFF) ? d1 : d0;
    side2_d.db   = d2;
    side2_d.s    = s1_q.s;
    side2_d.vmag = s1_q.vmag;
    side2_d.gg   = s1_q.gg;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q  <= side2_d;
      cx_q     <= {8'b0, s1_q.s, 24'b0};
      cy_q[0]  <= {{4{d1[D_W-1]}}, d1, 1'b0};
      cy_q[1]  <= {{4{d2[D_W-1]}}, d2, 1'b0};
    end
  end

  // ------------------------------------------------- normalize + CORDIC cells
  logic signed [CW-1:0] vx [2][ChainLen+1];
  logic signed [CW-1:0] vy [2][ChainLen+1];
  logic signed [ZW-1:0] vz [2][ATAN_STAGES+1];

  for (genvar g = 0; g < 2; g++) begin : g_lane
    assign vx[g][0] = cx_q;
    assign vy[g][0] = cy_q[g];
    assign vz[g][0] = '0;

    for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
      lce_norm_cell #(
        .SHIFT(NORM_SHIFT[k]),
        .LIMIT(NORM_LIMIT[k])
      ) u_norm (
        .clk_i(clk_i),
        .en_i (en),
        .x_i  (vx[g][k]),
        .y_i  (vy[g][k]),
        .x_o  (vx[g][k+1]),
        .y_o  (vy[g][k+1])
      );
    end

    for (genvar k = 0; k < ATAN_STAGES; k++) begin : g_rot
      lce_cordic_cell #(
        .STAGE(k)
      ) u_rot (
        .clk_i(clk_i),
        .en_i (en),
        .x_i  (vx[g][NORM_STAGES+k]),
        .y_i  (vy[g][NORM_STAGES+k]),
        .z_i  (vz[g][k]),
        .x_o  (vx[g][NORM_STAGES+k+1]),
        .y_o  (vy[g][NORM_STAGES+k+1]),
        .z_o  (vz[g][k+1])
      );
    end
  end

  lce_side_t side_q [ChainLen];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side2_q;
      for (int j = 1; j < ChainLen; j++) begin
        side_q[j] <= side_q[j-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage E1
  lce_side_t      sc;
  logic [ZW:0]    th, thn;
  logic [D_W-1:0] dan, dbn;
  logic           szero;
  e1_t            e1_d, e1_q;

  assign sc    = side_q[ChainLen-1];
  assign th    = {vz[0][ATAN_STAGES][ZW-1], vz[0][ATAN_STAGES]}
               - {vz[1][ATAN_STAGES][ZW-1], vz[1][ATAN_STAGES]};
  assign thn   = '0 - th;
  assign dan   = '0 - sc.da;
  assign dbn   = '0 - sc.db;
  assign szero = (sc.s == 32'd0);

  always_comb begin
    e1_d.mode = sc.mode;
    e1_d.pos  = (sc.vpos && !th[ZW] && (th != '0)) || (sc.vneg && th[ZW]);
    e1_d.eta  = sc.eta;
    e1_d.thm  = th[ZW] ? thn[ZW-1:0] : th[ZW-1:0];
    e1_d.vs   = sc.vmag * sc.s;
    e1_d.ada  = sc.da[D_W-1] ? dan[57:0] : sc.da[57:0];
    e1_d.adb  = sc.db[D_W-1] ? dbn[57:0] : sc.db[57:0];
    e1_d.s    = sc.s;
    e1_d.gg   = sc.gg;
    case (sc.mode)
      MODE_TRANS:  e1_d.err = szero && (sc.da == '0);
      MODE_STATIC: e1_d.err = szero;
      MODE_DIFF:   e1_d.err = szero && ((sc.da == '0) || (sc.db == '0));
      default:     e1_d.err = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q <= e1_d;
    end
  end

  // ---------------------------------------------------------------- stage E2
  logic [62:0] gg2;
  e2_t         e2_d, e2_q;

  assign gg2 = {e1_q.gg, 1'b0};

  always_comb begin
    e2_d.tail.mode = e1_q.mode;
    e2_d.tail.pos  = e1_q.pos;
    e2_d.tail.err  = e1_q.err;
    e2_d.tail.eta  = e1_q.eta;
    e2_d.ph  = gg2[62:32] * e1_q.thm;
    e2_d.pl  = gg2[31:0] * e1_q.thm;
    e2_d.vs  = e1_q.vs;
    e2_d.ahh = e1_q.ada[57:29] * e1_q.ada[57:29];
    e2_d.ahl = e1_q.ada[57:29] * e1_q.ada[28:0];
    e2_d.all = e1_q.ada[28:0] * e1_q.ada[28:0];
    e2_d.bhh = e1_q.adb[57:29] * e1_q.adb[57:29];
    e2_d.bhl = e1_q.adb[57:29] * e1_q.adb[28:0];
    e2_d.bll = e1_q.adb[28:0] * e1_q.adb[28:0];
    e2_d.ss  = e1_q.s * e1_q.s;
    e2_d.gg  = e1_q.gg;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e2_q <= e2_d;
    end
  end

  // ---------------------------------------------------------------- stage E3
  e3_t e3_d, e3_q;

  always_comb begin
    e3_d.tail = e2_q.tail;
    e3_d.snum = (DIV_W'(e2_q.ph) << 32) + DIV_W'(e2_q.pl);
    e3_d.vs   = e2_q.vs;
    e3_d.sqa  = (116'(e2_q.ahh) << 58) + (116'(e2_q.ahl) << 30) + 116'(e2_q.all);
    e3_d.sqb  = (116'(e2_q.bhh) << 58) + (116'(e2_q.bhl) << 30) + 116'(e2_q.bll);
    e3_d.ss   = e2_q.ss;
    e3_d.gg   = e2_q.gg;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e3_q <= e3_d;
    end
  end

  // ------------------------------------------------- stage E4, divider entry
  logic [DIV_W-1:0] tnum, dena, denb;
  logic [DIV_W-1:0] num_q [2];
  logic [DIV_W-1:0] den_q [2];
  lce_tail_t        tail4_q;

  assign tnum = DIV_W'(e3_q.gg) << 50;
  assign dena = (DIV_W'(e3_q.sqa) << 2) + (DIV_W'(e3_q.ss) << 48);
  assign denb = (DIV_W'(e3_q.sqb) << 2) + (DIV_W'(e3_q.ss) << 48);

  always_ff @(posedge clk_i) begin
    if (en) begin
      tail4_q <= e3_q.tail;
      if (e3_q.tail.mode == MODE_STATIC) begin
        num_q[0] <= e3_q.snum;
        den_q[0] <= DIV_W'(e3_q.vs) << 30;
      end else begin
        num_q[0] <= tnum;
        den_q[0] <= dena;
      end
      num_q[1] <= tnum;
      den_q[1] <= denb;
    end
  end

  // ------------------------------------------------------------ divider cells
  logic [DIV_W-1:0] drem [2][DivLen+1];
  logic [DIV_W-1:0] dden [2][DivLen+1];
  lce_quot_t        dquo [2][DivLen+1];

  for (genvar g = 0; g < 2; g++) begin : g_div
    assign drem[g][0] = num_q[g];
    assign dden[g][0] = den_q[g];
    assign dquo[g][0] = '0;

    for (genvar k = 0; k < DivLen; k++) begin : g_step
      lce_div_cell #(
        .INIT(k == 0)
      ) u_step (
        .clk_i (clk_i),
        .en_i  (en),
        .rem_i (drem[g][k]),
        .den_i (dden[g][k]),
        .quot_i(dquo[g][k]),
        .rem_o (drem[g][k+1]),
        .den_o (dden[g][k+1]),
        .quot_o(dquo[g][k+1])
      );
    end
  end

  lce_tail_t tail_q [DivLen];

  always_ff @(posedge clk_i) begin
    if (en) begin
      tail_q[0] <= tail4_q;
      for (int j = 1; j < DivLen; j++) begin
        tail_q[j] <= tail_q[j-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage F1
  lce_tail_t   tc;
  logic [24:0] qa, qb;
  f1_t         f1_d, f1_q;

  assign tc = tail_q[DivLen-1];
  assign qa = dquo[0][DivLen].sat ? ONE_Q24 : {1'b0, dquo[0][DivLen].q};
  assign qb = dquo[1][DivLen].sat ? ONE_Q24 : {1'b0, dquo[1][DivLen].q};

  always_comb begin
    f1_d.mode = tc.mode;
    f1_d.pos  = tc.pos;
    f1_d.err  = tc.err;
    f1_d.qa   = qa;
    f1_d.pa   = tc.eta * qa;
    f1_d.pb   = (ONE_Q24 - tc.eta) * qb;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q <= f1_d;
    end
  end

  // ------------------------------------------------------------ output stage
  logic [49:0] wsum;
  logic [24:0] g_d;
  lce_out_t    out_q;
  mode_e       out_mode_q;
  logic        out_pos_q;

  assign wsum = f1_q.pa + f1_q.pb;

  always_comb begin
    case (f1_q.mode)
      MODE_TRANS:  g_d = f1_q.qa;
      MODE_STATIC: g_d = f1_q.pos ? f1_q.qa : '0;
      MODE_DIFF:   g_d = wsum[48:24];
      default:     g_d = '0;
    endcase
    if (f1_q.err) begin
      g_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.conductance  <= g_d;
      out_q.divide_error <= f1_q.err;
      out_mode_q         <= f1_q.mode;
      out_pos_q          <= f1_q.pos;
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.divide_error |-> out_data_o.conductance == '0)
    else $error("divide error with nonzero conductance");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.conductance <= ONE_Q24)
    else $error("conductance above one");

  a_unused_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_mode_q == MODE_NONE |->
      !out_data_o.divide_error && out_data_o.conductance == '0)
    else $error("unused operation gave a result");

  a_static_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_mode_q == MODE_STATIC && !out_pos_q |->
      out_data_o.conductance == '0)
    else $error("static conductance nonzero with opposite angle sign");
`endif

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for lorentzian_conductance_eval: directed corner items,
// then random streams; every result is checked against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import lce_pkg::*;

  localparam int unsigned STAGES  = ATAN_STAGES_DEF;
  localparam int unsigned LATENCY = STAGES + 40;
  localparam int unsigned N_RAND  = 1710;
  localparam int unsigned ONE     = 32'h0100_0000;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  lce_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  lce_out_t out_data_o;

  lorentzian_conductance_eval u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // ---------------------------------------------------------------- predictor
  function automatic logic [127:0] frac_q24(logic [127:0] num, logic [127:0] den);
    logic [23:0] q;
    q = '0;
    if (num >= den) return 128'(ONE);
    for (int i = 0; i < 24; i++) begin
      num = num << 1;
      q = q << 1;
      if (num >= den) begin
        num = num - den;
        q[0] = 1'b1;
      end
    end
    return 128'(q);
  endfunction

  // transmission at offset d (Q.48); returns 1 on zero denominator
  function automatic bit trans_q24(longint d, logic [63:0] gl, logic [63:0] gr,
                                   output logic [127:0] t);
    logic [127:0] ad, s, den, num;
    ad  = d < 0 ? 128'(-d) : 128'(d);
    s   = 128'(gl + gr);
    den = ((ad * ad) << 2) + ((s * s) << 48);
    num = 128'(64'(4 * gl * gr)) << 48;
    t = '0;
    if (den == 0) return 1'b1;
    t = frac_q24(num, den);
    return 1'b0;
  endfunction

  function automatic longint atan_q30(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    while ((x < 0 ? -x : x) < (64'sd1 <<< 57) && (y < 0 ? -y : y) < (64'sd1 <<< 57)) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(ATAN_TABLE[i]);
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(ATAN_TABLE[i]);
      end
    end
    return z;
  endfunction

  function automatic lce_out_t predict_conductance(lce_in_t it);
    lce_out_t     r;
    longint       ef, v, eps, d0, d1, d2, th, xs;
    logic [63:0]  eta, gl, gr, s;
    logic [127:0] g, t1, t2, num, den;
    bit           err;
    ef  = longint'($signed(it.fermi_energy));
    v   = longint'($signed(it.bias));
    eps = longint'($signed(it.level_energy));
    eta = 64'(it.division);
    gl  = 64'(it.coupling_left);
    gr  = 64'(it.coupling_right);
    s   = gl + gr;
    g   = '0;
    err = 1'b0;
    if (eta > ONE) eta = ONE;
    d0 = (ef - eps) * 16777216;
    d1 = d0 + longint'(eta) * v;
    d2 = d1 - v * 16777216;
    if (it.operation == OP_ZERO_BIAS || (it.operation == OP_STATIC && v == 0)) begin
      err = trans_q24(d0, gl, gr, g);
    end else if (it.operation == OP_STATIC) begin
      if (s == 0) begin
        err = 1'b1;
      end else begin
        xs = longint'(s) * 16777216;
        th = atan_q30(xs, 2 * d1) - atan_q30(xs, 2 * d2);
        if ((v > 0 && th > 0) || (v < 0 && th < 0)) begin
          num = 128'(64'(2 * gl * gr)) * 128'(th < 0 ? -th : th);
          den = (128'(v < 0 ? -v : v) * 128'(s)) << 30;
          g = frac_q24(num, den);
        end
      end
    end else if (it.operation == OP_DIFF) begin
      err = trans_q24(d1, gl, gr, t1);
      err |= trans_q24(d2, gl, gr, t2);
      if (!err) g = (128'(eta) * t1 + 128'(ONE - eta) * t2) >> 24;
    end
    if (err) g = '0;
    if (g > ONE) g = ONE;
    r.conductance  = g[24:0];
    r.divide_error = err;
    return r;
  endfunction

  // --------------------------------------------------------------- scoreboard
  class conductance_board;
    lce_out_t pending[$];
    int       mismatches;

    function void note_item(lce_in_t it);
      pending.push_back(predict_conductance(it));
    endfunction

    function void check_result(lce_out_t got);
      lce_out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.conductance !== want.conductance || got.divide_error !== want.divide_error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: conductance exp %h got %h, error exp %b got %b",
                   want.conductance, got.conductance, want.divide_error, got.divide_error);
      end
    endfunction
  endclass

  conductance_board board;
  int  hold_cycles;     // long receiver hold-off, counted in the sink process

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int rand_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    return ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
  endfunction

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) board.note_item(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  // sink: random stalls, one long hold-off on request
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else if ($urandom_range(0, 2) == 0) begin
        n = rand_gap();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(negedge clk_i);
        end
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_item(lce_in_t it);
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_source(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_energy();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      2: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom())};
      default: return 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
    endcase
  endfunction

  function automatic logic [30:0] rand_coupling();
    case ($urandom_range(0, 4))
      0: return 31'($urandom());
      1: return 31'($urandom_range(0, 32'h0100_0000));
      2: return 31'($urandom_range(0, 32'h0010_0000));
      3: return 31'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 255));
      default: return 31'($urandom_range(0, 32'h0800_0000));
    endcase
  endfunction

  function automatic lce_in_t rand_item();
    lce_in_t it;
    it.operation      = ($urandom_range(0, 30) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
    it.fermi_energy   = rand_energy();
    it.bias           = ($urandom_range(0, 10) == 0) ? 32'd0 : rand_energy();
    it.division       = ($urandom_range(0, 7) == 0) ? 25'($urandom())
                                                    : 25'($urandom_range(0, ONE));
    it.level_energy   = ($urandom_range(0, 6) == 0) ? it.fermi_energy : rand_energy();
    it.coupling_left  = rand_coupling();
    it.coupling_right = ($urandom_range(0, 8) == 0) ? 31'd0 : rand_coupling();
    if ($urandom_range(0, 15) == 0) begin
      it.coupling_left  = '0;
      it.coupling_right = '0;
    end
    return it;
  endfunction

  function automatic lce_in_t mk(logic [1:0] op, logic [31:0] ef, logic [31:0] v,
                                 logic [24:0] eta, logic [31:0] eps,
                                 logic [30:0] gl, logic [30:0] gr);
    lce_in_t it;
    it = '{op, ef, v, eta, eps, gl, gr};
    return it;
  endfunction

  initial begin
    lce_in_t directed[$];
    int      limit;
    board       = new();
    hold_cycles = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // corners: each op, zero bias, zero couplings, eta extremes and above one
    directed.push_back(mk(OP_ZERO_BIAS, 0, 0, 0, 0, 31'h0100_0000, 31'h0100_0000));
    directed.push_back(mk(OP_ZERO_BIAS, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OP_ZERO_BIAS, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, '1, '1));
    directed.push_back(mk(OP_ZERO_BIAS, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, '1, 0));
    directed.push_back(mk(OP_STATIC, 0, 0, 0, 32'h0100_0000, 31'h80_0000, 31'h80_0000));
    directed.push_back(mk(OP_STATIC, 0, 32'h0100_0000, 25'h80_0000, 0, 0, 0));
    directed.push_back(mk(OP_STATIC, 0, 32'h0100_0000, 25'h80_0000, 0, 31'h10_0000, 31'h10_0000));
    directed.push_back(mk(OP_STATIC, 0, 32'hFF00_0000, 25'h80_0000, 0, 31'h10_0000, 31'h30_0000));
    directed.push_back(mk(OP_STATIC, 32'h7FFF_FFFF, 32'h8000_0000, 25'h1FF_FFFF,
                          32'h8000_0000, '1, '1));
    directed.push_back(mk(OP_STATIC, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 1, 1));
    directed.push_back(mk(OP_STATIC, 0, 32'h0000_0001, ONE_Q24, 0, 31'h100, 31'h1));
    directed.push_back(mk(OP_DIFF, 0, 32'h0100_0000, 0, 0, 31'h10_0000, 31'h10_0000));
    directed.push_back(mk(OP_DIFF, 0, 32'h0100_0000, ONE_Q24, 0, 31'h10_0000, 31'h10_0000));
    directed.push_back(mk(OP_DIFF, 0, 32'h0200_0000, 25'h1FF_FFFF, 0, 31'h10_0000, 31'h20_0000));
    directed.push_back(mk(OP_DIFF, 0, 0, 25'h80_0000, 0, 0, 0));
    directed.push_back(mk(OP_DIFF, 0, 32'h0100_0000, 25'h80_0000, 0, 0, 0));
    directed.push_back(mk(OP_DIFF, 32'h8000_0000, 32'h8000_0000, 25'h1FF_FFFF,
                          32'h7FFF_FFFF, '1, '1));
    directed.push_back(mk(OP_UNUSED, 32'h1234_5678, 32'h0100_0000, ONE_Q24, 0, '1, '1));
    directed.push_back(mk(OP_UNUSED, '1, '1, '1, '1, '1, '1));
    foreach (directed[i]) send_item(directed[i]);

    // wait for drain: sender pause until all results are back
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);

    // long receiver hold-off while items keep coming
    hold_cycles = 3 * LATENCY;
    for (int i = 0; i < 120; i++) send_item(rand_item());

    for (int i = 0; i < N_RAND; i++) begin
      if ($urandom_range(0, 2) == 0) idle_source(rand_gap());
      send_item(rand_item());
    end
    in_valid_i <= 1'b0;

    limit = 200000;
    while (board.pending.size() != 0 && limit > 0) begin
      @(negedge clk_i);
      limit--;
    end
    repeat (LATENCY + 10) @(negedge clk_i);
    if (limit > 0 && board.pending.size() == 0 && board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
